// ===== design/fbpd_pkg.sv =====
// Shared types and constants for the four-button short/long press decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package fbpd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] MODE_LONG_RESET = 32'd2000;
  localparam logic [TIME_W-1:0] TRACK_LONG_RESET = 32'd600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE_LONG  = 2'd0,
    CFG_TRACK_LONG = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_SLEEP       = 3'd1,
    ACT_NEXT_MODE   = 3'd2,
    ACT_TOGGLE_PLAY = 3'd3,
    ACT_PREV_TRACK  = 3'd4,
    ACT_VOL_DOWN    = 3'd5,
    ACT_NEXT_TRACK  = 3'd6,
    ACT_VOL_UP      = 3'd7
  } action_t;

  typedef struct packed {
    logic long_hit;
    logic short_hit;
  } press_evt_t;

endpackage

`default_nettype wire

// ===== design/four_button_short_long_press_decoder.sv =====
// Top level of the four-button short/long press decoder.
// Depends on fbpd_pkg and fbpd_press_unit.
//
// Each input beat is one poll of the four buttons with the current millisecond time, and it
// yields exactly one output beat carrying an action code (none when nothing happened). A poll
// is captured in an input register, decoded combinationally against the per-button state, and
// the action lands in an output register, so one poll per clock is sustained while the output
// side is ready; a stalled output holds the input register. The decode is a single
// subtract-and-compare per press unit. The two threshold registers may be written at any time
// the block is idle and are always ready.
`default_nettype none

module four_button_short_long_press_decoder
  import fbpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [TIME_W-1:0]    in_now_ms,
  input  wire logic                 in_mode_down,
  input  wire logic                 in_play_down,
  input  wire logic                 in_minus_down,
  input  wire logic                 in_plus_down,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_action,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data
);

  logic              in_valid_r;
  logic [TIME_W-1:0] now_r;
  logic              mode_r, play_r, minus_r, plus_r;
  logic              out_valid_r;
  action_t           action_r, action_nxt;
  logic              play_held_r;
  logic [TIME_W-1:0] mode_long_r, track_long_r;
  logic              advance;
  press_evt_t        mode_evt, minus_evt, plus_evt;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_action = action_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_long_r  <= MODE_LONG_RESET;
      track_long_r <= TRACK_LONG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE_LONG:  mode_long_r  <= cfg_data;
        CFG_TRACK_LONG: track_long_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r   <= in_now_ms;
      mode_r  <= in_mode_down;
      play_r  <= in_play_down;
      minus_r <= in_minus_down;
      plus_r  <= in_plus_down;
    end
  end

  fbpd_press_unit u_mode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .level    (mode_r),
    .now_ms   (now_r),
    .limit_ms (mode_long_r),
    .evt      (mode_evt)
  );

  fbpd_press_unit u_minus (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .level    (minus_r),
    .now_ms   (now_r),
    .limit_ms (track_long_r),
    .evt      (minus_evt)
  );

  fbpd_press_unit u_plus (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .level    (plus_r),
    .now_ms   (now_r),
    .limit_ms (track_long_r),
    .evt      (plus_evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_held_r <= 1'b0;
    end else if (advance) begin
      play_held_r <= play_r;
    end
  end

  // The later button in the poll order wins when several actions arise.
  always_comb begin
    priority if (plus_evt.long_hit) begin
      action_nxt = ACT_NEXT_TRACK;
    end else if (plus_evt.short_hit) begin
      action_nxt = ACT_VOL_UP;
    end else if (minus_evt.long_hit) begin
      action_nxt = ACT_PREV_TRACK;
    end else if (minus_evt.short_hit) begin
      action_nxt = ACT_VOL_DOWN;
    end else if (play_r && !play_held_r) begin
      action_nxt = ACT_TOGGLE_PLAY;
    end else if (mode_evt.long_hit) begin
      action_nxt = ACT_SLEEP;
    end else if (mode_evt.short_hit) begin
      action_nxt = ACT_NEXT_MODE;
    end else begin
      action_nxt = ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action_r <= action_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/fbpd_press_unit.sv =====
// Per-button press tracker for one button with short and long actions.
// Depends on fbpd_pkg for the time width and the event struct.
`default_nettype none

module fbpd_press_unit
  import fbpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              level,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [TIME_W-1:0] limit_ms,
  output press_evt_t             evt
);

  logic              held_r, held_nxt;
  logic              long_done_r, long_done_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;
  logic [TIME_W-1:0] elapsed;

  assign elapsed = now_ms - stamp_r;

  always_comb begin
    held_nxt      = held_r;
    long_done_nxt = long_done_r;
    stamp_nxt     = stamp_r;
    evt           = '0;
    if (level && !held_r) begin
      held_nxt      = 1'b1;
      stamp_nxt     = now_ms;
      long_done_nxt = 1'b0;
    end else if (level) begin
      if ((elapsed > limit_ms) && !long_done_r) begin
        long_done_nxt = 1'b1;
        evt.long_hit  = 1'b1;
      end
    end else if (held_r) begin
      evt.short_hit = !long_done_r;
      held_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      long_done_r <= 1'b0;
      stamp_r     <= '0;
    end else if (step) begin
      held_r      <= held_nxt;
      long_done_r <= long_done_nxt;
      stamp_r     <= stamp_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/fbpd_checker.sv =====
// Port-level checker for the four-button short/long press decoder, bound to its top level.
// Depends on fbpd_pkg for widths.
`default_nettype none

module fbpd_checker
  import fbpd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           out_action,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind four_button_short_long_press_decoder fbpd_checker u_fbpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_action (out_action),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire

// ===== sim/four_button_short_long_press_decoder_test.sv =====
`timescale 1ns / 100ps
// Self-checking test of four_button_short_long_press_decoder, with directed and random polls.
// Depends on fbpd_pkg and the decoder RTL; it predicts each action and checks every output beat.

module four_button_short_long_press_decoder_test;
  import fbpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic [3:0] KEY_NONE  = 4'b0000;
  localparam logic [3:0] KEY_MODE  = 4'b0001;
  localparam logic [3:0] KEY_PLAY  = 4'b0010;
  localparam logic [3:0] KEY_MINUS = 4'b0100;
  localparam logic [3:0] KEY_PLUS  = 4'b1000;
  localparam logic [3:0] KEY_ALL   = 4'b1111;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 in_mode_down = 1'b0;
  logic                 in_play_down = 1'b0;
  logic                 in_minus_down = 1'b0;
  logic                 in_plus_down = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_action;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;

  logic [TIME_W-1:0] mode_limit_ms;
  logic [TIME_W-1:0] track_limit_ms;
  logic [3:0]        held_now;
  logic [TIME_W-1:0] press_stamp [3];
  logic [2:0]        long_fired;

  action_t           pending_actions [$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       out_hold_left = 0;
  bit                idle_on = 1'b1;
  logic [TIME_W-1:0] poll_ms = '0;
  logic [3:0]        btn_levels = '0;

  four_button_short_long_press_decoder u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_now_ms    (in_now_ms),
    .in_mode_down (in_mode_down),
    .in_play_down (in_play_down),
    .in_minus_down(in_minus_down),
    .in_plus_down (in_plus_down),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_action   (out_action),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_predictor();
    mode_limit_ms = MODE_LONG_RESET;
    track_limit_ms = TRACK_LONG_RESET;
    held_now = '0;
    long_fired = '0;
    for (int k = 0; k < 3; k++) press_stamp[k] = '0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [TIME_W-1:0] data);
    case (idx)
      CFG_MODE_LONG:  mode_limit_ms = data;
      CFG_TRACK_LONG: track_limit_ms = data;
      default: ;
    endcase
  endfunction

  function automatic action_t decode_button(input int slot, input int k, input logic level,
                                            input logic [TIME_W-1:0] now,
                                            input logic [TIME_W-1:0] limit,
                                            input action_t long_act, input action_t short_act);
    action_t           act;
    logic [TIME_W-1:0] elapsed;
    act = ACT_NONE;
    elapsed = now - press_stamp[k];
    if (level && !held_now[slot]) begin
      held_now[slot] = 1'b1;
      press_stamp[k] = now;
      long_fired[k] = 1'b0;
    end else if (level) begin
      if (elapsed > limit && !long_fired[k]) begin
        long_fired[k] = 1'b1;
        act = long_act;
      end
    end else if (held_now[slot]) begin
      if (!long_fired[k]) act = short_act;
      held_now[slot] = 1'b0;
    end
    return act;
  endfunction

  function automatic action_t decode_poll(input logic [TIME_W-1:0] now, input logic [3:0] levels);
    action_t act;
    action_t unit_act;
    act = ACT_NONE;
    unit_act = decode_button(0, 0, levels[0], now, mode_limit_ms, ACT_SLEEP, ACT_NEXT_MODE);
    if (unit_act != ACT_NONE) act = unit_act;
    if (levels[1] && !held_now[1]) begin
      held_now[1] = 1'b1;
      act = ACT_TOGGLE_PLAY;
    end else if (!levels[1]) begin
      held_now[1] = 1'b0;
    end
    unit_act = decode_button(2, 1, levels[2], now, track_limit_ms, ACT_PREV_TRACK, ACT_VOL_DOWN);
    if (unit_act != ACT_NONE) act = unit_act;
    unit_act = decode_button(3, 2, levels[3], now, track_limit_ms, ACT_NEXT_TRACK, ACT_VOL_UP);
    if (unit_act != ACT_NONE) act = unit_act;
    return act;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic send_poll(input logic [TIME_W-1:0] now, input logic [3:0] levels);
    while (idle_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_now_ms <= now;
    in_mode_down <= levels[0];
    in_play_down <= levels[1];
    in_minus_down <= levels[2];
    in_plus_down <= levels[3];
    do @(posedge clk); while (!in_ready);
    pending_actions.push_back(decode_poll(now, levels));
  endtask

  task automatic settle_outputs();
    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
    settle_outputs();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, data);
  endtask

  task automatic run_random_polls(input int count);
    int          sel;
    logic [TIME_W-1:0] step_ms;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        btn_levels = 4'($urandom_range(15));
      end else begin
        for (int b = 0; b < 4; b++) begin
          if ($urandom_range(99) < 15) btn_levels[b] = ~btn_levels[b];
        end
      end
      sel = $urandom_range(99);
      if (sel < 60) step_ms = $urandom_range(50);
      else if (sel < 85) step_ms = $urandom_range(1200);
      else if (sel < 97) step_ms = $urandom_range(3000);
      else step_ms = $urandom;
      poll_ms += step_ms;
      send_poll(poll_ms, btn_levels);
    end
  endtask

  task automatic test_single_buttons();
    send_poll(32'd0, KEY_NONE);
    send_poll(32'd10, KEY_MODE);
    send_poll(32'd2010, KEY_MODE);
    send_poll(32'd2011, KEY_MODE);
    send_poll(32'd2500, KEY_MODE);
    send_poll(32'd2600, KEY_NONE);
    send_poll(32'd3000, KEY_MODE);
    send_poll(32'd3100, KEY_NONE);
    send_poll(32'd3200, KEY_PLAY);
    send_poll(32'd3300, KEY_PLAY);
    send_poll(32'd3400, KEY_NONE);
    send_poll(32'd3500, KEY_MINUS);
    send_poll(32'd4100, KEY_MINUS);
    send_poll(32'd4101, KEY_MINUS);
    send_poll(32'd4200, KEY_NONE);
    send_poll(32'd4300, KEY_MINUS);
    send_poll(32'd4350, KEY_NONE);
    send_poll(32'd4400, KEY_PLUS);
    send_poll(32'd5001, KEY_PLUS);
    send_poll(32'd5100, KEY_NONE);
    send_poll(32'd5200, KEY_PLUS);
    send_poll(32'd5250, KEY_NONE);
  endtask

  task automatic test_priority();
    send_poll(32'd6000, KEY_ALL);
    send_poll(32'd6100, KEY_NONE);
    send_poll(32'd6200, KEY_MODE | KEY_MINUS);
    send_poll(32'd6300, KEY_NONE);
    send_poll(32'd7000, KEY_MODE | KEY_MINUS | KEY_PLUS);
    send_poll(32'd9100, KEY_MODE | KEY_MINUS | KEY_PLUS);
    send_poll(32'd9150, KEY_NONE);
    send_poll(32'd9200, KEY_MODE);
    send_poll(32'd11300, KEY_MODE | KEY_PLAY);
    send_poll(32'd11400, KEY_NONE);
  endtask

  task automatic test_time_wrap();
    send_poll(32'hFFFF_FF00, KEY_PLUS);
    send_poll(32'h0000_0158, KEY_PLUS);
    send_poll(32'h0000_0159, KEY_PLUS);
    send_poll(32'hFFFF_FFFF, KEY_MODE);
    send_poll(32'h0000_0200, KEY_NONE);
  endtask

  task automatic test_threshold_extremes();
    write_reg(CFG_TRACK_LONG, 32'd0);
    write_reg(CFG_MODE_LONG, 32'hFFFF_FFFF);
    send_poll(32'd100, KEY_MINUS);
    send_poll(32'd100, KEY_MINUS);
    send_poll(32'd101, KEY_MINUS);
    send_poll(32'd150, KEY_NONE);
    send_poll(32'd200, KEY_MODE);
    send_poll(32'd199, KEY_MODE);
    send_poll(32'd210, KEY_NONE);
    write_reg(CFG_TRACK_LONG, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_2, 32'd0);
    write_reg(CFG_SPARE_3, 32'd5);
    send_poll(32'd300, KEY_PLUS | KEY_MINUS);
    send_poll(32'd299, KEY_PLUS | KEY_MINUS);
    send_poll(32'd305, KEY_NONE);
    write_reg(CFG_MODE_LONG, 32'd0);
    send_poll(32'd400, KEY_MODE);
    send_poll(32'd401, KEY_MODE);
    send_poll(32'd402, KEY_NONE);
  endtask

  task automatic test_random_traffic();
    write_reg(CFG_MODE_LONG, MODE_LONG_RESET);
    write_reg(CFG_TRACK_LONG, TRACK_LONG_RESET);
    poll_ms = $urandom;
    run_random_polls(220);
    write_reg(CFG_MODE_LONG, 32'($urandom_range(300)));
    write_reg(CFG_TRACK_LONG, 32'($urandom_range(150)));
    idle_on = 1'b0;
    run_random_polls(220);
    idle_on = 1'b1;
    write_reg(CFG_MODE_LONG, $urandom);
    write_reg(CFG_TRACK_LONG, $urandom);
    run_random_polls(200);
    write_reg(CFG_MODE_LONG, 32'hFFFF_FFFF);
    write_reg(CFG_TRACK_LONG, 32'd0);
    run_random_polls(200);
  endtask

  task automatic test_backpressure();
    settle_outputs();
    out_hold_left = 120;
    idle_on = 1'b0;
    run_random_polls(40);
    idle_on = 1'b1;
    settle_outputs();
    run_random_polls(30);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("unexpected output beat, action %0d", out_action));
      end else if (out_action !== pending_actions[0]) begin
        report_mismatch($sformatf("action %0d, expected %s", out_action,
                                  pending_actions[0].name()));
        void'(pending_actions.pop_front());
      end else begin
        void'(pending_actions.pop_front());
      end
    end
    if (out_hold_left > 0) begin
      out_ready <= 1'b0;
      out_hold_left--;
    end else if (idle_on) begin
      out_ready <= ($urandom_range(99) >= 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_buttons();
    test_priority();
    test_time_wrap();
    test_threshold_extremes();
    test_random_traffic();
    test_backpressure();
    settle_outputs();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
